// File: rtl/clcd_pkg.sv
// ----------------------------------------------------------------------------
// clcd_pkg
// Shared types and constants for the 4-bit character LCD sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package clcd_pkg;

  localparam int OP_W      = 3;
  localparam int CFG_IDX_W = 3;
  localparam int TICK_W    = 16;

  localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
  localparam logic [OP_W-1:0] OP_INIT   = 3'd1;
  localparam logic [OP_W-1:0] OP_WRITE  = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
  localparam logic [OP_W-1:0] OP_HOME   = 3'd4;
  localparam logic [OP_W-1:0] OP_CURSOR = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_POWER_UP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_INIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_INIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NIBBLE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_CMD   = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0] operation;
    logic [7:0]      data_byte;
    logic            register_select;
    logic [5:0]      column;
    logic            line;
  } clcd_item_t;

  typedef struct packed {
    logic [TICK_W-1:0] power_up_ticks;
    logic [TICK_W-1:0] long_init_ticks;
    logic [TICK_W-1:0] short_init_ticks;
    logic [TICK_W-1:0] nibble_ticks;
    logic [TICK_W-1:0] slow_command_ticks;
  } clcd_cfg_t;

  typedef struct packed {
    logic       rs_pin;
    logic       en_pin;
    logic [3:0] data_nibble;
    logic       busy_res;
    logic       rejected;
  } clcd_result_t;

endpackage

`default_nettype wire

// File: rtl/clcd_cfg.sv
// ----------------------------------------------------------------------------
// clcd_cfg
// Timing registers of the LCD sequencer, loaded through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module clcd_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [clcd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [clcd_pkg::TICK_W-1:0]   cfg_wdata,
  output clcd_pkg::clcd_cfg_t                cfg_o
);
  import clcd_pkg::*;

  clcd_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.power_up_ticks     <= 16'd3000;
      cfg_r.long_init_ticks    <= 16'd410;
      cfg_r.short_init_ticks   <= 16'd10;
      cfg_r.nibble_ticks       <= 16'd20;
      cfg_r.slow_command_ticks <= 16'd200;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_POWER_UP:   cfg_r.power_up_ticks     <= cfg_wdata;
        CFG_LONG_INIT:  cfg_r.long_init_ticks    <= cfg_wdata;
        CFG_SHORT_INIT: cfg_r.short_init_ticks   <= cfg_wdata;
        CFG_NIBBLE:     cfg_r.nibble_ticks       <= cfg_wdata;
        CFG_SLOW_CMD:   cfg_r.slow_command_ticks <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_r;

endmodule

`default_nettype wire

// File: rtl/clcd_in_stage.sv
// ----------------------------------------------------------------------------
// clcd_in_stage
// Input register stage with a valid/ready handshake on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module clcd_in_stage (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire clcd_pkg::clcd_item_t  in_item,
  output logic                       s_valid,
  input  wire logic                  s_ready,
  output clcd_pkg::clcd_item_t       s_item
);
  import clcd_pkg::*;

  logic       valid_r;
  clcd_item_t item_r;

  assign in_ready = !valid_r || s_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

  assign s_valid = valid_r;
  assign s_item  = item_r;

endmodule

`default_nettype wire

// File: rtl/clcd_seq.sv
// ----------------------------------------------------------------------------
// clcd_seq
// Sequencer state, next-state logic for one request and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module clcd_seq (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire clcd_pkg::clcd_cfg_t   cfg_i,
  input  wire logic                  s_valid,
  output logic                       s_ready,
  input  wire clcd_pkg::clcd_item_t  s_item,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output clcd_pkg::clcd_result_t     out_res
);
  import clcd_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE, PH_POWER, PH_INIT, PH_HIGH, PH_LOW, PH_SLOW
  } phase_t;

  localparam logic [3:0] STEP_LONE      = 4'd8;
  localparam logic [3:0] STEP_LONE_SLOW = 4'd9;
  localparam logic [3:0] STEP_FIRST_CMD = 4'd4;
  localparam logic [3:0] STEP_LAST_INIT = 4'd3;
  localparam logic [3:0] STEP_CLEAR     = 4'd7;

  localparam logic [7:0] INIT_BYTES [4] = '{8'h0C, 8'h06, 8'h28, 8'h01};

  phase_t       phase_r, phase_nxt;
  logic [3:0]   step_r, step_nxt;
  logic [15:0]  wait_r, wait_nxt;
  logic [7:0]   hbyte_r, hbyte_nxt;
  logic         hrs_r, hrs_nxt;
  logic [5:0]   pins_r, pins_nxt;
  logic         ovalid_r;
  clcd_result_t res_r, res_nxt;

  logic         busy;
  logic         rej;
  logic         take;
  logic [15:0]  hold;
  logic [7:0]   cursor_byte;
  logic [3:0]   step_inc;

  assign s_ready = !ovalid_r || out_ready;
  assign take    = s_valid && s_ready;
  assign busy    = (phase_r != PH_IDLE);
  assign step_inc = step_r + 4'd1;
  assign cursor_byte = 8'h80 + {2'b00, s_item.column} + (s_item.line ? 8'h40 : 8'h00);

  always_comb begin
    hold = cfg_i.nibble_ticks;
    if (phase_r == PH_INIT) begin
      case (step_r[1:0])
        2'd0:    hold = cfg_i.long_init_ticks;
        2'd1:    hold = cfg_i.short_init_ticks;
        2'd2:    hold = cfg_i.long_init_ticks;
        default: hold = cfg_i.slow_command_ticks;
      endcase
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    step_nxt  = step_r;
    wait_nxt  = wait_r;
    hbyte_nxt = hbyte_r;
    hrs_nxt   = hrs_r;
    pins_nxt  = pins_r;
    rej       = 1'b0;
    case (s_item.operation)
      OP_TICK: begin
        if (busy) begin
          case (phase_r)
            PH_POWER, PH_SLOW: begin
              if (wait_r > 16'd1) begin
                wait_nxt = wait_r - 16'd1;
              end else if (phase_r == PH_POWER) begin
                phase_nxt = PH_INIT;
                step_nxt  = 4'd0;
                pins_nxt  = {2'b00, 4'h3};
                wait_nxt  = 16'd0;
              end else begin
                phase_nxt = PH_IDLE;
                step_nxt  = 4'd0;
                wait_nxt  = 16'd0;
              end
            end
            PH_INIT, PH_HIGH, PH_LOW: begin
              if (!pins_r[4]) begin
                pins_nxt[4] = 1'b1;
                wait_nxt    = hold;
              end else if (wait_r > 16'd1) begin
                wait_nxt = wait_r - 16'd1;
              end else begin
                pins_nxt[4] = 1'b0;
                wait_nxt    = 16'd0;
                if (phase_r == PH_INIT) begin
                  if (step_r < STEP_LAST_INIT) begin
                    step_nxt = step_inc;
                    pins_nxt = {2'b00, (step_inc == STEP_LAST_INIT) ? 4'h2 : 4'h3};
                  end else begin
                    hbyte_nxt = INIT_BYTES[0];
                    hrs_nxt   = 1'b0;
                    step_nxt  = STEP_FIRST_CMD;
                    phase_nxt = PH_HIGH;
                    pins_nxt  = {2'b00, INIT_BYTES[0][7:4]};
                  end
                end else if (phase_r == PH_HIGH) begin
                  phase_nxt = PH_LOW;
                  pins_nxt  = {hrs_r, 1'b0, hbyte_r[3:0]};
                end else if (step_r >= STEP_FIRST_CMD && step_r < STEP_CLEAR) begin
                  hbyte_nxt = INIT_BYTES[step_r[1:0] + 2'd1];
                  hrs_nxt   = 1'b0;
                  step_nxt  = step_inc;
                  phase_nxt = PH_HIGH;
                  pins_nxt  = {2'b00, INIT_BYTES[step_r[1:0] + 2'd1][7:4]};
                end else if (step_r == STEP_CLEAR || step_r == STEP_LONE_SLOW) begin
                  phase_nxt = PH_SLOW;
                  wait_nxt  = cfg_i.slow_command_ticks;
                end else begin
                  phase_nxt = PH_IDLE;
                  step_nxt  = 4'd0;
                end
              end
            end
            default: begin
              phase_nxt = PH_IDLE;
              step_nxt  = 4'd0;
              wait_nxt  = 16'd0;
            end
          endcase
        end
      end
      OP_INIT, OP_WRITE, OP_CLEAR, OP_HOME, OP_CURSOR: begin
        if (busy) begin
          rej = 1'b1;
        end else if (s_item.operation == OP_INIT) begin
          phase_nxt = PH_POWER;
          step_nxt  = 4'd0;
          pins_nxt  = 6'd0;
          wait_nxt  = cfg_i.power_up_ticks;
        end else begin
          phase_nxt = PH_HIGH;
          wait_nxt  = 16'd0;
          case (s_item.operation)
            OP_WRITE: begin
              hbyte_nxt = s_item.data_byte;
              hrs_nxt   = s_item.register_select;
              step_nxt  = STEP_LONE;
            end
            OP_CLEAR: begin
              hbyte_nxt = 8'h01;
              hrs_nxt   = 1'b0;
              step_nxt  = STEP_LONE_SLOW;
            end
            OP_HOME: begin
              hbyte_nxt = 8'h02;
              hrs_nxt   = 1'b0;
              step_nxt  = STEP_LONE_SLOW;
            end
            default: begin
              hbyte_nxt = cursor_byte;
              hrs_nxt   = 1'b0;
              step_nxt  = STEP_LONE;
            end
          endcase
          pins_nxt = {hrs_nxt, 1'b0, hbyte_nxt[7:4]};
        end
      end
      default: begin
      end
    endcase

    res_nxt.rs_pin      = pins_nxt[5];
    res_nxt.en_pin      = pins_nxt[4];
    res_nxt.data_nibble = pins_nxt[3:0];
    res_nxt.busy_res    = (phase_nxt != PH_IDLE);
    res_nxt.rejected    = rej;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      step_r   <= 4'd0;
      wait_r   <= 16'd0;
      hbyte_r  <= 8'd0;
      hrs_r    <= 1'b0;
      pins_r   <= 6'd0;
      ovalid_r <= 1'b0;
    end else begin
      if (take) begin
        phase_r <= phase_nxt;
        step_r  <= step_nxt;
        wait_r  <= wait_nxt;
        hbyte_r <= hbyte_nxt;
        hrs_r   <= hrs_nxt;
        pins_r  <= pins_nxt;
        res_r   <= res_nxt;
      end
      if (s_ready) begin
        ovalid_r <= s_valid;
      end
    end
  end

  assign out_valid = ovalid_r;
  assign out_res   = res_r;

endmodule

`default_nettype wire

// File: rtl/char_lcd_4bit_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_4bit_sequencer
// Character LCD controller for a 4-bit bus with RS and EN lines.
// ----------------------------------------------------------------------------
// Path: a request accepted at the input is held in the input register and
// then loaded into the result register, where it waits to be taken.
// Throughput: one request per cycle while out_ready does not hold the
// result; the sequencer update is one pass between input and result registers.
// Reset is synchronous and active low: the sequencer returns to idle with its
// pin state cleared and the timing registers take their default values.
`default_nettype none

module char_lcd_4bit_sequencer (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [clcd_pkg::OP_W-1:0]      in_operation,
  input  wire logic [7:0]                     in_data_byte,
  input  wire logic                           in_register_select,
  input  wire logic [5:0]                     in_column,
  input  wire logic                           in_line,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_rs_pin,
  output logic                                out_en_pin,
  output logic [3:0]                          out_data_nibble,
  output logic                                out_busy_res,
  output logic                                out_rejected,
  input  wire logic                           cfg_wr_en,
  input  wire logic [clcd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [clcd_pkg::TICK_W-1:0]    cfg_wdata
);
  import clcd_pkg::*;

  clcd_item_t   in_item;
  clcd_item_t   s_item;
  logic         s_valid;
  logic         s_ready;
  clcd_cfg_t    cfg;
  clcd_result_t res;

  assign in_item.operation       = in_operation;
  assign in_item.data_byte       = in_data_byte;
  assign in_item.register_select = in_register_select;
  assign in_item.column          = in_column;
  assign in_item.line            = in_line;

  clcd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  clcd_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .s_item   (s_item)
  );

  clcd_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_i     (cfg),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_item    (s_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_rs_pin      = res.rs_pin;
  assign out_en_pin      = res.en_pin;
  assign out_data_nibble = res.data_nibble;
  assign out_busy_res    = res.busy_res;
  assign out_rejected    = res.rejected;

endmodule

`default_nettype wire

// File: verif/clcd_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// clcd_scoreboard_pkg
// Scoreboard for the 4-bit character LCD sequencer. It keeps its own copy of
// the timing registers and the sequencer state, predicts the pin levels and
// flags for every accepted request, and checks the results in order.
// ----------------------------------------------------------------------------
package clcd_scoreboard_pkg;
  import clcd_pkg::*;

  typedef enum logic [2:0] {
    SEQ_IDLE, SEQ_POWER, SEQ_INIT, SEQ_HIGH, SEQ_LOW, SEQ_SLOW
  } seq_phase_e;

  localparam logic [3:0] STEP_SWITCH     = 4'd3;
  localparam logic [3:0] STEP_FIRST_BYTE = 4'd4;
  localparam logic [3:0] STEP_LAST_BYTE  = 4'd6;
  localparam logic [3:0] STEP_INIT_TAIL  = 4'd7;
  localparam logic [3:0] STEP_WRITE_ONLY = 4'd8;
  localparam logic [3:0] STEP_SLOW_TAIL  = 4'd9;
  localparam int         EN_POS          = 4;

  localparam logic [3:0] NIB_WAKE     = 4'h3;
  localparam logic [3:0] NIB_FOUR_BIT = 4'h2;

  localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
  localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
  localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
  localparam logic [7:0] CMD_CLEAR        = 8'h01;
  localparam logic [7:0] CMD_HOME         = 8'h02;
  localparam logic [7:0] CMD_SET_ADDR     = 8'h80;
  localparam logic [7:0] LINE1_OFFSET     = 8'h40;

  class lcd_scoreboard;
    clcd_cfg_t    timing;
    seq_phase_e   phase;
    logic [3:0]   step;
    logic [15:0]  wait_cnt;
    logic [7:0]   byte_q;
    logic         rs_q;
    logic [5:0]   pins;
    clcd_result_t expected_q[$];
    int           mismatches;
    int           checked;
    int           requests;
    int           commands;
    int           rejections;
    int           inits;

    function new();
      timing = '{power_up_ticks: 16'd3000, long_init_ticks: 16'd410,
                 short_init_ticks: 16'd10, nibble_ticks: 16'd20,
                 slow_command_ticks: 16'd200};
      phase      = SEQ_IDLE;
      step       = '0;
      wait_cnt   = '0;
      byte_q     = '0;
      rs_q       = 1'b0;
      pins       = '0;
      mismatches = 0;
      checked    = 0;
      requests   = 0;
      commands   = 0;
      rejections = 0;
      inits      = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [TICK_W-1:0] val);
      case (idx)
        CFG_POWER_UP:   timing.power_up_ticks     = val;
        CFG_LONG_INIT:  timing.long_init_ticks    = val;
        CFG_SHORT_INIT: timing.short_init_ticks   = val;
        CFG_NIBBLE:     timing.nibble_ticks       = val;
        CFG_SLOW_CMD:   timing.slow_command_ticks = val;
        default: ;
      endcase
    endfunction

    function bit busy();
      return phase != SEQ_IDLE;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function logic [7:0] setup_byte(logic [1:0] k);
      case (k)
        2'd0:    return CMD_DISPLAY_ON;
        2'd1:    return CMD_ENTRY_MODE;
        2'd2:    return CMD_FUNCTION_SET;
        default: return CMD_CLEAR;
      endcase
    endfunction

    function void load_bus(logic rs, logic [3:0] nib);
      pins     = {rs, 1'b0, nib};
      wait_cnt = '0;
    endfunction

    function void start_byte(logic [7:0] b, logic rs, logic [3:0] stp);
      byte_q = b;
      rs_q   = rs;
      step   = stp;
      phase  = SEQ_HIGH;
      load_bus(rs, b[7:4]);
    endfunction

    function void go_idle();
      phase    = SEQ_IDLE;
      step     = '0;
      wait_cnt = '0;
    endfunction

    function logic [15:0] hold_ticks();
      if (phase == SEQ_INIT) begin
        case (step[1:0])
          2'd0:    return timing.long_init_ticks;
          2'd1:    return timing.short_init_ticks;
          2'd2:    return timing.long_init_ticks;
          default: return timing.slow_command_ticks;
        endcase
      end
      return timing.nibble_ticks;
    endfunction

    // The strobe has just dropped: move on to the next nibble, byte or wait, or go idle.
    function void pulse_done();
      if (phase == SEQ_INIT) begin
        if (step < STEP_SWITCH) begin
          step = step + 4'd1;
          load_bus(1'b0, (step == STEP_SWITCH) ? NIB_FOUR_BIT : NIB_WAKE);
        end else begin
          start_byte(setup_byte(2'd0), 1'b0, STEP_FIRST_BYTE);
        end
      end else if (phase == SEQ_HIGH) begin
        phase = SEQ_LOW;
        load_bus(rs_q, byte_q[3:0]);
      end else if (step >= STEP_FIRST_BYTE && step <= STEP_LAST_BYTE) begin
        start_byte(setup_byte(2'(step - STEP_SWITCH)), 1'b0, step + 4'd1);
      end else if (step == STEP_INIT_TAIL || step == STEP_SLOW_TAIL) begin
        phase    = SEQ_SLOW;
        wait_cnt = timing.slow_command_ticks;
      end else begin
        go_idle();
      end
    endfunction

    function void advance_tick();
      case (phase)
        SEQ_POWER, SEQ_SLOW: begin
          if (wait_cnt > 16'd1) begin
            wait_cnt = wait_cnt - 16'd1;
          end else if (phase == SEQ_POWER) begin
            phase = SEQ_INIT;
            step  = '0;
            load_bus(1'b0, NIB_WAKE);
          end else begin
            go_idle();
          end
        end
        SEQ_INIT, SEQ_HIGH, SEQ_LOW: begin
          if (!pins[EN_POS]) begin
            pins[EN_POS] = 1'b1;
            wait_cnt     = hold_ticks();
          end else if (wait_cnt > 16'd1) begin
            wait_cnt = wait_cnt - 16'd1;
          end else begin
            pins[EN_POS] = 1'b0;
            wait_cnt     = '0;
            pulse_done();
          end
        end
        default: go_idle();
      endcase
    endfunction

    function void note_request(clcd_item_t it);
      bit         was_busy;
      bit         turned_away;
      logic [7:0] addr;
      was_busy    = busy();
      turned_away = 1'b0;
      requests++;
      if (it.operation == OP_TICK) begin
        if (was_busy) advance_tick();
      end else if (it.operation <= OP_CURSOR) begin
        commands++;
        if (was_busy) begin
          turned_away = 1'b1;
          rejections++;
        end else begin
          case (it.operation)
            OP_INIT: begin
              phase = SEQ_POWER;
              step  = '0;
              load_bus(1'b0, 4'h0);
              wait_cnt = timing.power_up_ticks;
              inits++;
            end
            OP_WRITE: start_byte(it.data_byte, it.register_select, STEP_WRITE_ONLY);
            OP_CLEAR: start_byte(CMD_CLEAR, 1'b0, STEP_SLOW_TAIL);
            OP_HOME:  start_byte(CMD_HOME, 1'b0, STEP_SLOW_TAIL);
            default: begin
              addr = CMD_SET_ADDR + {2'b00, it.column} + (it.line ? LINE1_OFFSET : 8'h00);
              start_byte(addr, 1'b0, STEP_WRITE_ONLY);
            end
          endcase
        end
      end
      expected_q.push_back('{rs_pin: pins[5], en_pin: pins[EN_POS], data_nibble: pins[3:0],
                             busy_res: busy(), rejected: turned_away});
    endfunction

    task report(string msg);
      $display("ERROR: %s", msg);
      mismatches++;
    endtask

    task compare_field(string name, logic [3:0] got, logic [3:0] want);
      if (got !== want)
        report($sformatf("result %0d: %s is %0h, expected %0h", checked, name, got, want));
    endtask

    task check_result(clcd_result_t got);
      clcd_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0d arrived with no request waiting for it", checked));
        return;
      end
      want = expected_q.pop_front();
      compare_field("rs_pin", got.rs_pin, want.rs_pin);
      compare_field("en_pin", got.en_pin, want.en_pin);
      compare_field("data_nibble", got.data_nibble, want.data_nibble);
      compare_field("busy_res", got.busy_res, want.busy_res);
      compare_field("rejected", got.rejected, want.rejected);
      checked++;
    endtask
  endclass

endpackage

// File: verif/tb_char_lcd_4bit_sequencer.sv
// ----------------------------------------------------------------------------
// tb_char_lcd_4bit_sequencer
// Self-checking bench for the 4-bit character LCD sequencer. Directed requests
// cover every operation, busy rejection and the timing extremes; random
// requests then run under several timing settings with random gaps and
// back-pressure, and every result is checked against the scoreboard.
// ----------------------------------------------------------------------------
module tb_char_lcd_4bit_sequencer;
  import clcd_pkg::*;
  import clcd_scoreboard_pkg::*;

  localparam int    RANDOM_PHASES   = 5;
  localparam int    ITEMS_PER_PHASE = 140;
  localparam longint CYCLE_LIMIT    = 2_000_000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [OP_W-1:0]      in_operation;
  logic [7:0]           in_data_byte;
  logic                 in_register_select;
  logic [5:0]           in_column;
  logic                 in_line;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_rs_pin;
  logic                 out_en_pin;
  logic [3:0]           out_data_nibble;
  logic                 out_busy_res;
  logic                 out_rejected;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [TICK_W-1:0]    cfg_wdata;

  lcd_scoreboard sb;
  bit            quiet;
  int            rx_hold = 0;
  int            settings_used = 0;
  longint        cycles = 0;

  char_lcd_4bit_sequencer dut (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycles, sb.pending());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        sb.check_result(clcd_result_t'({out_rs_pin, out_en_pin, out_data_nibble,
                                        out_busy_res, out_rejected}));
        rx_hold = quiet ? 0 : $urandom_range(0, 15);
      end else if (rx_hold > 0) begin
        rx_hold--;
      end
      out_ready <= (rx_hold == 0);
    end
  end

  function automatic clcd_item_t request_of(logic [OP_W-1:0] op, logic [7:0] db,
                                            logic rs, logic [5:0] col, logic ln);
    return '{operation: op, data_byte: db, register_select: rs, column: col, line: ln};
  endfunction

  function automatic clcd_item_t random_fields(logic [OP_W-1:0] op);
    return request_of(op, 8'($urandom), 1'($urandom), 6'($urandom), 1'($urandom));
  endfunction

  function automatic clcd_item_t random_request();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick >= 93) return random_fields(OP_W'($urandom_range(6, 7)));
    if (pick >= 72) return random_fields(OP_W'($urandom_range(OP_INIT, OP_CURSOR)));
    return random_fields(OP_TICK);
  endfunction

  function automatic logic [TICK_W-1:0] random_ticks();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return TICK_W'($urandom_range(10, 60));
      default: return TICK_W'($urandom_range(1, 6));
    endcase
  endfunction

  task automatic send_request(clcd_item_t it);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_operation       <= it.operation;
    in_data_byte       <= it.data_byte;
    in_register_select <= it.register_select;
    in_column          <= it.column;
    in_line            <= it.line;
    do @(posedge clk); while (!in_ready);
    sb.note_request(it);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Ticks until the sequencer is back to idle, then lets every result drain.
  task automatic settle();
    while (sb.busy()) send_request(random_fields(OP_TICK));
    wait_drained();
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TICK_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic apply_timing(clcd_cfg_t t);
    settle();
    write_reg(CFG_POWER_UP, t.power_up_ticks);
    write_reg(CFG_LONG_INIT, t.long_init_ticks);
    write_reg(CFG_SHORT_INIT, t.short_init_ticks);
    write_reg(CFG_NIBBLE, t.nibble_ticks);
    write_reg(CFG_SLOW_CMD, t.slow_command_ticks);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  initial begin
    clcd_item_t it;
    int         counted;
    sb                 = new();
    quiet              = 1'b1;
    rst_n              <= 1'b0;
    in_valid           <= 1'b0;
    in_operation       <= OP_TICK;
    in_data_byte       <= '0;
    in_register_select <= 1'b0;
    in_column          <= '0;
    in_line            <= 1'b0;
    cfg_wr_en          <= 1'b0;
    cfg_index          <= CFG_POWER_UP;
    cfg_wdata          <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset timing: idle tick, ignored codes, every command and busy rejection.
    send_request(request_of(OP_TICK, 8'h00, 1'b0, 6'd0, 1'b0));
    send_request(request_of(OP_W'(6), 8'hFF, 1'b1, 6'd63, 1'b1));
    send_request(request_of(OP_W'(7), 8'h00, 1'b0, 6'd0, 1'b0));
    send_request(request_of(OP_WRITE, 8'hFF, 1'b1, 6'd0, 1'b0));
    send_request(request_of(OP_INIT, 8'h00, 1'b0, 6'd0, 1'b0));
    send_request(request_of(OP_WRITE, 8'h00, 1'b0, 6'd0, 1'b0));
    send_request(request_of(OP_CLEAR, 8'h00, 1'b0, 6'd0, 1'b0));
    send_request(request_of(OP_HOME, 8'h00, 1'b0, 6'd0, 1'b0));
    send_request(request_of(OP_CURSOR, 8'h00, 1'b0, 6'd63, 1'b1));
    settle();
    send_request(request_of(OP_WRITE, 8'h00, 1'b0, 6'd63, 1'b1));
    settle();
    send_request(request_of(OP_CLEAR, 8'h00, 1'b0, 6'd0, 1'b0));
    settle();
    send_request(request_of(OP_HOME, 8'h00, 1'b0, 6'd0, 1'b0));
    settle();
    send_request(request_of(OP_CURSOR, 8'h00, 1'b0, 6'd0, 1'b0));
    settle();
    send_request(request_of(OP_CURSOR, 8'h00, 1'b0, 6'd63, 1'b1));
    settle();
    send_request(request_of(OP_CURSOR, 8'h00, 1'b0, 6'd63, 1'b0));
    settle();

    // Zero holds behave as one tick.
    apply_timing('0);
    send_request(request_of(OP_INIT, 8'h00, 1'b0, 6'd0, 1'b0));
    send_request(request_of(OP_W'(7), 8'h5A, 1'b1, 6'd21, 1'b1));
    send_request(request_of(OP_CURSOR, 8'h00, 1'b0, 6'd5, 1'b0));
    settle();
    send_request(request_of(OP_WRITE, 8'hA5, 1'b1, 6'd0, 1'b0));
    settle();
    send_request(request_of(OP_CURSOR, 8'h00, 1'b0, 6'd42, 1'b1));
    settle();

    // Long power-up, switch nibble and clear waits beside the shortest holds.
    apply_timing('{power_up_ticks: 16'd120, long_init_ticks: 16'd2,
                   short_init_ticks: 16'd0, nibble_ticks: 16'd1,
                   slow_command_ticks: 16'd100});
    send_request(request_of(OP_INIT, 8'h00, 1'b0, 6'd0, 1'b0));
    settle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      quiet = 1'b0;
      apply_timing('{power_up_ticks: random_ticks(), long_init_ticks: random_ticks(),
                     short_init_ticks: random_ticks(), nibble_ticks: random_ticks(),
                     slow_command_ticks: random_ticks()});
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        it = random_request();
        if ((it.operation >= OP_INIT && it.operation <= OP_CURSOR) ||
            (it.operation == OP_TICK && sb.busy()))
          counted++;
        send_request(it);
        if ($urandom_range(0, 39) == 0) quiet = !quiet;
        if ($urandom_range(0, 99) == 0) wait_drained();
      end
    end

    quiet = 1'b0;
    settle();
    repeat (8) @(posedge clk);

    $display("Covered %0d requests: %0d commands, %0d turned away while busy, %0d init runs,",
             sb.requests, sb.commands, sb.rejections, sb.inits);
    $display("under %0d timing settings after reset; %0d results checked.",
             settings_used, sb.checked);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
